/* rtl/tone_or_sample_player_unit_macros.svh */
// assertion macros for the tone or sample player
`ifndef TONE_OR_SAMPLE_PLAYER_UNIT_MACROS_SVH
`define TONE_OR_SAMPLE_PLAYER_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define TOSP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define TOSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/tosp_pkg.sv */
// shared types, codes and the quarter-wave sine table of the tone or sample player
`timescale 1ns / 1ps
`default_nettype none

package tosp_pkg;

    localparam int SOUND_DEPTH         = 65536;
    localparam int QUARTER_SINE_POINTS = 256;
    localparam int QSP_W               = $clog2(QUARTER_SINE_POINTS);

    // divider operand widths: dividend covers 2^32, divisor covers sample_rate
    localparam int DIV_NW = 33;
    localparam int DIV_DW = 18;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // command codes (s_tuser)
    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_RESTART = 2'd1;
    localparam logic [1:0] CMD_SAMPLE  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_TONE_HZ      = 2'd0;
    localparam logic [1:0] REG_TONE_VOLUME  = 2'd1;
    localparam logic [1:0] REG_SAMPLE_RATE  = 2'd2;
    localparam logic [1:0] REG_SOUND_LENGTH = 2'd3;

    localparam logic [14:0] RST_TONE_HZ      = 15'd512;
    localparam logic [14:0] RST_TONE_VOLUME  = 15'd3000;
    localparam logic [17:0] RST_SAMPLE_RATE  = 18'd48000;
    localparam logic [16:0] RST_SOUND_LENGTH = 17'd0;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef logic [QUARTER_SINE_POINTS-1:0][14:0] qsine_tbl_t;

    // round(32767 * sin(angle)), angle in q30 over [0, pi/2], taylor series
    function automatic logic [14:0] sine_q15(input logic [63:0] angle);
        logic        [63:0] x2;
        logic        [63:0] term;
        logic signed [63:0] sum;
        logic        [63:0] v;
        x2   = (angle * angle) >> 30;
        term = angle;
        sum  = $signed(angle);
        term = ((term * x2) >> 30) / 6;    sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 20;   sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 42;   sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 72;   sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 110;  sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 156;  sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 210;  sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 272;  sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 342;  sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 420;  sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 506;  sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 600;  sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 702;  sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 812;  sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 930;  sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 1056; sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 1190; sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 1332; sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 1482; sum = sum - $signed(term);
        if (sum < 0)
        begin
            sum = 0;
        end
        v = (64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767)
        begin
            v = 64'd32767;
        end
        return v[14:0];
    endfunction

    function automatic qsine_tbl_t build_qsine();
        qsine_tbl_t  tbl;
        logic [63:0] angle;
        for (int k = 0; k < QUARTER_SINE_POINTS; k++)
        begin
            angle = (64'(k) * HALF_PI_Q30 + 64'(QUARTER_SINE_POINTS / 2))
                    / 64'(QUARTER_SINE_POINTS);
            tbl[k] = sine_q15(angle);
        end
        return tbl;
    endfunction

    localparam qsine_tbl_t  QSINE      = build_qsine();
    // entry at exactly pi/2, reached only by the mirrored index
    localparam logic [14:0] QSINE_PEAK = sine_q15(HALF_PI_Q30);

endpackage

`default_nettype wire

/* rtl/tosp_ram.sv */
// generic single-port-write, registered-read ram
`timescale 1ns / 1ps
`default_nettype none

module tosp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/tosp_div.sv */
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module tosp_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [tosp_pkg::DIV_NW-1:0] dividend,
    input  wire logic [tosp_pkg::DIV_DW-1:0] divisor,
    output      tosp_pkg::div_stat_t         stat,
    output      logic [tosp_pkg::DIV_NW-1:0] quotient,
    output      logic [tosp_pkg::DIV_DW-1:0] remainder
);

    localparam int NW  = tosp_pkg::DIV_NW;
    localparam int DW  = tosp_pkg::DIV_DW;
    localparam int CW  = $clog2(NW + 1);

    logic [CW-1:0] cnt_reg,  cnt_next;
    logic [NW-1:0] quo_reg,  quo_next;
    logic [DW-1:0] rem_reg,  rem_next;
    logic [DW-1:0] dsr_reg,  dsr_next;
    logic          done_reg, done_next;

    logic [DW:0] shifted;
    logic [DW:0] diff;
    logic        fits;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[NW-1]};
        diff      = shifted - {1'b0, dsr_reg};
        fits      = shifted >= {1'b0, dsr_reg};
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        done_next = 1'b0;
        if (start && cnt_reg == '0)
        begin
            cnt_next = CW'(NW);
            quo_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = fits ? diff[DW-1:0] : shifted[DW-1:0];
            quo_next  = {quo_reg[NW-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

/* rtl/tone_or_sample_player_unit.sv */
// top level of the tone or sample player
//
// input stream s_*: one command per transfer. s_tuser carries the command
// (load sound word, restart playback, produce one sample). a load writes the
// sound store and a restart clears the play position, both in the accept
// cycle with no result. a sample command gives one result on m_*: the 16-bit
// sample and, in m_tuser, whether it came from the stored sound or the sine.
// a sample command steps through tick, latch and result; the result step
// writes the result register and returns to idle. with buffer_start set,
// the mode is chosen first: playing sound adds one 33-step division for the
// pointer, the sine mode adds two back-to-back divisions for period and
// phase step, all on one shared restoring divider. s_tready is high only
// while the sequencer is idle. the result sits in an output register; a new
// command is taken while it waits, and a following sample command holds in
// its last step until the receiver takes the previous result. registers are
// written on cfg_* only while the block is idle, a rule the user must keep;
// the block does not enforce it. reset clears position, pointer, phase,
// step and registers to defaults; sound store is undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

`include "tone_or_sample_player_unit_macros.svh"

module tone_or_sample_player_unit #(
    parameter int SOUND_DEPTH = tosp_pkg::SOUND_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // s_tdata: load_address[15:0], load_value[31:16], buffer_start[32], zero pad
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [39:0] s_tdata,
    // s_tuser: command[1:0]
    input  wire logic [1:0]  s_tuser,
    // m_tdata: sample[15:0]
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [15:0] m_tdata,
    // m_tuser: from_sound[0]
    output      logic        m_tuser,
    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [17:0] cfg_data
);

    localparam int SOUND_AW = $clog2(SOUND_DEPTH);
    localparam int QSP      = tosp_pkg::QUARTER_SINE_POINTS;
    localparam int QW       = tosp_pkg::QSP_W;
    localparam int NW       = tosp_pkg::DIV_NW;
    localparam int DW       = tosp_pkg::DIV_DW;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_PER,
        ST_DIV_STEP,
        ST_DIV_PTR,
        ST_TICK,
        ST_LATCH,
        ST_RESULT
    } state_t;

    // configuration
    logic [14:0] tone_hz_reg;
    logic [14:0] tone_volume_reg;
    logic [17:0] sample_rate_reg;
    logic [16:0] sound_length_reg;

    // sequencer state and registered outputs
    state_t      state_reg,     state_next;
    logic [31:0] pos_reg,       pos_next;
    logic [15:0] rp_reg,        rp_next;
    logic        playing_reg,   playing_next;
    logic [31:0] phase_reg,     phase_next;
    logic [31:0] step_reg,      step_next;
    logic [14:0] sine_mag_reg,  sine_mag_next;
    logic        sine_neg_reg,  sine_neg_next;
    logic [14:0] prod_reg,      prod_next;
    logic        m_tvalid_reg,  m_tvalid_next;
    logic [15:0] m_sample_reg,  m_sample_next;
    logic        m_from_reg,    m_from_next;

    logic        s_accept;
    logic [1:0]  cmd;
    logic        buf_start;
    logic        pos_in_sound;

    logic                 ram_we;
    logic                 ram_re;
    logic [15:0]          ram_rdata;

    logic                 div_start;
    logic [NW-1:0]        div_a;
    logic [DW-1:0]        div_b;
    tosp_pkg::div_stat_t  div_stat;
    logic [NW-1:0]        div_q;
    logic [DW-1:0]        div_r;

    logic [14:0]          hz_eff;
    logic [DW-1:0]        period;
    logic [15:0]          rp_inc;
    logic [QW-1:0]        sine_idx;
    logic [QW:0]          sine_idx_m;
    logic [14:0]          sine_val;
    logic [29:0]          prod_full;
    logic [15:0]          sine_sample;

    assign s_accept     = s_tvalid && s_tready;
    assign cmd          = s_tuser;
    assign buf_start    = s_tdata[32];
    assign pos_in_sound = pos_reg < {15'd0, sound_length_reg};
    assign s_tready     = (state_reg == ST_IDLE);
    assign cfg_ready    = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tone_hz_reg      <= tosp_pkg::RST_TONE_HZ;
            tone_volume_reg  <= tosp_pkg::RST_TONE_VOLUME;
            sample_rate_reg  <= tosp_pkg::RST_SAMPLE_RATE;
            sound_length_reg <= tosp_pkg::RST_SOUND_LENGTH;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                tosp_pkg::REG_TONE_HZ:      tone_hz_reg      <= cfg_data[14:0];
                tosp_pkg::REG_TONE_VOLUME:  tone_volume_reg  <= cfg_data[14:0];
                tosp_pkg::REG_SAMPLE_RATE:  sample_rate_reg  <= cfg_data;
                tosp_pkg::REG_SOUND_LENGTH: sound_length_reg <= cfg_data[16:0];
                default:                    ;
            endcase
        end
    end

    tosp_ram #(
        .WIDTH (16),
        .DEPTH (SOUND_DEPTH)
    ) u_sound_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (SOUND_AW'(s_tdata[15:0])),
        .wdata (s_tdata[31:16]),
        .re    (ram_re),
        .raddr (SOUND_AW'(rp_reg)),
        .rdata (ram_rdata)
    );

    tosp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .stat      (div_stat),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // quarter-wave lookup: top phase bits pick the quadrant, odd ones mirror
    always_comb
    begin
        sine_idx   = phase_reg[29 -: QW];
        sine_idx_m = phase_reg[30] ? ((QW+1)'(QSP) - {1'b0, sine_idx}) : {1'b0, sine_idx};
        sine_val   = sine_idx_m[QW] ? tosp_pkg::QSINE_PEAK
                                    : tosp_pkg::QSINE[sine_idx_m[QW-1:0]];
    end

    assign hz_eff      = (tone_hz_reg == '0) ? 15'd1 : tone_hz_reg;
    assign period      = (div_q[DW-1:0] == '0) ? DW'(1) : div_q[DW-1:0];
    assign rp_inc      = rp_reg + 16'd1;
    assign prod_full   = 30'(sine_mag_reg) * 30'(tone_volume_reg);
    assign sine_sample = sine_neg_reg ? (16'd0 - {1'b0, prod_reg}) : {1'b0, prod_reg};

    always_comb
    begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        rp_next       = rp_reg;
        playing_next  = playing_reg;
        phase_next    = phase_reg;
        step_next     = step_reg;
        sine_mag_next = sine_mag_reg;
        sine_neg_next = sine_neg_reg;
        prod_next     = prod_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_sample_next = m_sample_reg;
        m_from_next   = m_from_reg;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        div_start     = 1'b0;
        div_a         = {17'd0, pos_reg[15:0]};
        div_b         = {1'b0, sound_length_reg};

        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    case (cmd)
                        tosp_pkg::CMD_LOAD:
                        begin
                            ram_we = 1'b1;
                        end
                        tosp_pkg::CMD_RESTART:
                        begin
                            pos_next = '0;
                            rp_next  = '0;
                        end
                        tosp_pkg::CMD_SAMPLE:
                        begin
                            if (buf_start)
                            begin
                                playing_next = pos_in_sound;
                                div_start    = 1'b1;
                                if (pos_in_sound)
                                begin
                                    div_a      = {1'b0, pos_reg};
                                    div_b      = {1'b0, sound_length_reg};
                                    state_next = ST_DIV_PTR;
                                end
                                else
                                begin
                                    div_a      = NW'(sample_rate_reg);
                                    div_b      = DW'(hz_eff);
                                    state_next = ST_DIV_PER;
                                end
                            end
                            else
                            begin
                                state_next = ST_TICK;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_DIV_PER:
            begin
                if (div_stat.done)
                begin
                    // step = 2^32 / period, wraps to zero when period is one
                    div_start  = 1'b1;
                    div_a      = {1'b1, 32'd0};
                    div_b      = period;
                    state_next = ST_DIV_STEP;
                end
            end
            ST_DIV_STEP:
            begin
                if (div_stat.done)
                begin
                    step_next  = div_q[31:0];
                    state_next = ST_TICK;
                end
            end
            ST_DIV_PTR:
            begin
                if (div_stat.done)
                begin
                    rp_next    = div_r[15:0];
                    state_next = ST_TICK;
                end
            end
            ST_TICK:
            begin
                if (playing_reg)
                begin
                    ram_re   = 1'b1;
                    rp_next  = ({1'b0, rp_inc} >= sound_length_reg) ? 16'd0 : rp_inc;
                    pos_next = pos_reg + 32'd1;
                end
                else
                begin
                    sine_mag_next = sine_val;
                    sine_neg_next = phase_reg[31];
                    phase_next    = phase_reg + step_reg;
                end
                state_next = ST_LATCH;
            end
            ST_LATCH:
            begin
                prod_next  = prod_full[29:15];
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_sample_next = playing_reg ? ram_rdata : sine_sample;
                    m_from_next   = playing_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pos_reg      <= '0;
            rp_reg       <= '0;
            playing_reg  <= 1'b0;
            phase_reg    <= '0;
            step_reg     <= '0;
            sine_mag_reg <= '0;
            sine_neg_reg <= 1'b0;
            prod_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            m_sample_reg <= '0;
            m_from_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            rp_reg       <= rp_next;
            playing_reg  <= playing_next;
            phase_reg    <= phase_next;
            step_reg     <= step_next;
            sine_mag_reg <= sine_mag_next;
            sine_neg_reg <= sine_neg_next;
            prod_reg     <= prod_next;
            m_tvalid_reg <= m_tvalid_next;
            m_sample_reg <= m_sample_next;
            m_from_reg   <= m_from_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_sample_reg;
    assign m_tuser  = m_from_reg;

    `TOSP_ASSERT_NOW(a_div_quiet_when_idle, state_reg == ST_IDLE, !div_stat.busy,
        "divider busy while sequencer idle")
    `TOSP_ASSERT_NOW(a_div_done_in_div_state, div_stat.done,
        state_reg == ST_DIV_PER || state_reg == ST_DIV_STEP || state_reg == ST_DIV_PTR,
        "divider finished outside a division step")
    `TOSP_ASSERT_NEXT(a_result_from_last_step, state_reg != ST_RESULT && !m_tvalid_reg,
        !m_tvalid_reg, "result appeared without passing the result step")

endmodule

`default_nettype wire
